[rtl/hid_report_rx_deframer_fifo_top_macros.svh]
// Assertion macros for the HID report deframer.
`ifndef HID_REPORT_RX_DEFRAMER_FIFO_TOP_MACROS_SVH
`define HID_REPORT_RX_DEFRAMER_FIFO_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define HRDF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hrdf: same-cycle check failed");
// Next-cycle implication.
`define HRDF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hrdf: next-cycle check failed");
`else
`define HRDF_ASSERT_NOW(label, clk, rst_n, ante, cons)
`define HRDF_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

[rtl/hrdf_pkg.sv]
// Shared types and constants for the HID report deframer.
`timescale 1ns / 1ps

package hrdf_pkg;

    typedef enum logic [1:0] {
        CMD_HEADER = 2'd0,
        CMD_BYTE   = 2'd1,
        CMD_POP    = 2'd2,
        CMD_REARM  = 2'd3
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE      = 3'd0,
        ST_HDR_OK    = 3'd1,
        ST_HDR_IGN   = 3'd2,
        ST_HDR_REF   = 3'd3,
        ST_STORED    = 3'd4,
        ST_DISCARDED = 3'd5
    } t_status;

    localparam logic [7:0] ID_SMALL  = 8'd1;
    localparam logic [7:0] ID_LARGE  = 8'd2;
    localparam logic [7:0] CAP_SMALL = 8'd13;
    localparam logic [7:0] CAP_LARGE = 8'd29;

    // Header decision handed from the checker to the ring control.
    typedef struct packed {
        t_status    status;
        logic [4:0] len;
    } t_hdr_dec;

endpackage

[rtl/hid_report_rx_deframer_fifo_top.sv]
// Top level of the HID output report deframer and byte ring.
`timescale 1ns / 1ps
//
// Usage
//   Input channel (i_item_valid / o_item_stall) carries one command word:
//   a packet header (count, report id, length), a packet byte, a pop or a
//   rearm. Output channel (o_res_valid / i_res_stall) returns exactly one
//   result word per command: status, popped byte, rearm, stall flag, drop
//   count and ring fill level after that command.
//   A word passes the input register, then the result register, on its way
//   to the result. Throughput: one word per cycle sustained while i_res_stall
//   is low; all state updates are single adds and compares between the input
//   register and the result register, and the ring is read and written once
//   per cycle through one port each.
//   Receiver stall: the result register holds; the input register still
//   holds one word, after which o_item_stall rises. No word is lost.
//   Reset (synchronous, active low) clears pointers, stall flag, drop count
//   and pending byte count at once; the ring store itself is not cleared and
//   needs no clearing pass, since only written slots are ever popped.
//   Packet length is clamped to the bytes present and to 13 (id 1) or 29
//   (id 2); one ring slot is always kept free.
`include "hid_report_rx_deframer_fifo_top_macros.svh"

module hid_report_rx_deframer_fifo_top #(
    parameter int RING_DEPTH       = 256,
    parameter int PACKET_MAX_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command words
    input  logic        i_item_valid,
    output logic        o_item_stall,
    input  logic [1:0]  i_cmd,
    input  logic [6:0]  i_packet_bytes,
    input  logic [7:0]  i_report_id,
    input  logic [7:0]  i_length_field,
    input  logic [7:0]  i_data_byte,
    // result words
    output logic        o_res_valid,
    input  logic        i_res_stall,
    output logic [2:0]  o_status,
    output logic [7:0]  o_out_byte,
    output logic        o_out_valid,
    output logic        o_rearm,
    output logic        o_stalled,
    output logic [15:0] o_drop_count,
    output logic [7:0]  o_fill_level
);

    localparam int PW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    // fill width: holds the depth and is at least a byte wide for the port
    localparam int FW = (PW + 1 > 8) ? PW + 1 : 8;

    // ring store, no reset
    logic [7:0] r_ring [RING_DEPTH];

    // input register
    logic        r_s1_vld;
    logic [1:0]  r_s1_cmd;
    logic [6:0]  r_s1_cnt;
    logic [7:0]  r_s1_id;
    logic [7:0]  r_s1_len;
    logic [7:0]  r_s1_data;

    // control state
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic          r_stall_flag, n_stall_flag;
    logic [15:0]   r_drop_cnt, n_drop_cnt;
    logic [4:0]    r_to_store, n_to_store;
    // the packet's remaining byte count never shows at the outputs and is
    // not kept

    // result register
    logic          r_res_vld;
    logic [2:0]    r_status, n_status;
    logic          r_popv, n_popv;
    logic          r_rearm, n_rearm;
    logic [7:0]    r_pop_data;
    logic [FW-1:0] r_fill, n_fill;

    logic          s2_load;
    logic          s1_adv;
    logic          do_write;
    logic          do_read;
    logic [FW-1:0] used;
    logic [FW-1:0] n_used;
    logic [FW-1:0] free;
    logic [PW-1:0] wr_next;
    logic [PW-1:0] rd_next;
    hrdf_pkg::t_cmd     s1_cmd;
    hrdf_pkg::t_hdr_dec hdr_dec;

    assign s2_load      = !r_res_vld || !i_res_stall;
    assign s1_adv       = r_s1_vld && s2_load;
    assign o_item_stall = r_s1_vld && !s2_load;
    assign s1_cmd       = hrdf_pkg::t_cmd'(r_s1_cmd);

    assign wr_next = (r_wr_ptr == PW'(RING_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
    assign rd_next = (r_rd_ptr == PW'(RING_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;

    always_comb begin
        if (r_wr_ptr >= r_rd_ptr) begin
            used = FW'(r_wr_ptr) - FW'(r_rd_ptr);
        end else begin
            used = FW'(r_wr_ptr) + FW'(RING_DEPTH) - FW'(r_rd_ptr);
        end
        free = FW'(RING_DEPTH - 1) - used;
    end

    hrdf_hdr_check #(
        .PACKET_MAX_BYTES (PACKET_MAX_BYTES),
        .FREE_W           (FW)
    ) u_hdr_check (
        .i_count (r_s1_cnt),
        .i_id    (r_s1_id),
        .i_len   (r_s1_len),
        .i_free  (free),
        .o_dec   (hdr_dec)
    );

    // per-command state update
    always_comb begin
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        n_stall_flag = r_stall_flag;
        n_drop_cnt   = r_drop_cnt;
        n_to_store   = r_to_store;
        n_status     = hrdf_pkg::ST_IDLE;
        n_popv       = 1'b0;
        n_rearm      = 1'b0;
        do_write     = 1'b0;
        do_read      = 1'b0;
        case (s1_cmd)
            hrdf_pkg::CMD_HEADER: begin
                n_status   = hdr_dec.status;
                n_to_store = hdr_dec.len;
                if (hdr_dec.status == hrdf_pkg::ST_HDR_REF) begin
                    n_drop_cnt   = r_drop_cnt + 16'd1;
                    n_stall_flag = 1'b1;
                end
            end
            hrdf_pkg::CMD_BYTE: begin
                n_status = hrdf_pkg::ST_DISCARDED;
                if (r_to_store != 5'd0) begin
                    n_to_store = r_to_store - 5'd1;
                    if (used < FW'(RING_DEPTH - 1)) begin
                        do_write = 1'b1;
                        n_wr_ptr = wr_next;
                        n_status = hrdf_pkg::ST_STORED;
                    end
                end
            end
            hrdf_pkg::CMD_POP: begin
                if (r_wr_ptr != r_rd_ptr) begin
                    do_read  = 1'b1;
                    n_popv   = 1'b1;
                    n_rd_ptr = rd_next;
                end
            end
            hrdf_pkg::CMD_REARM: begin
                if (r_stall_flag) begin
                    n_stall_flag = 1'b0;
                    n_rearm      = 1'b1;
                end
            end
            default: begin
                n_status = hrdf_pkg::ST_IDLE;
            end
        endcase
        // fill after this word: at most one of write and read happens
        n_used = used;
        if (do_write) begin
            n_used = used + 1'b1;
        end else if (do_read) begin
            n_used = used - 1'b1;
        end
        n_fill = n_used;
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld     <= 1'b0;
            r_res_vld    <= 1'b0;
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_stall_flag <= 1'b0;
            r_drop_cnt   <= 16'd0;
            r_to_store   <= 5'd0;
        end else begin
            if (!o_item_stall) begin
                r_s1_vld <= i_item_valid;
            end
            if (s2_load) begin
                r_res_vld <= r_s1_vld;
            end
            if (s1_adv) begin
                r_wr_ptr     <= n_wr_ptr;
                r_rd_ptr     <= n_rd_ptr;
                r_stall_flag <= n_stall_flag;
                r_drop_cnt   <= n_drop_cnt;
                r_to_store   <= n_to_store;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (!o_item_stall && i_item_valid) begin
            r_s1_cmd  <= i_cmd;
            r_s1_cnt  <= i_packet_bytes;
            r_s1_id   <= i_report_id;
            r_s1_len  <= i_length_field;
            r_s1_data <= i_data_byte;
        end
        if (s1_adv) begin
            r_status <= n_status;
            r_popv   <= n_popv;
            r_rearm  <= n_rearm;
            r_fill   <= n_fill;
        end
    end

    // ring port: one write, one registered read; a pop never shares its word with a write
    always_ff @(posedge i_clk) begin
        if (s1_adv && do_write) begin
            r_ring[r_wr_ptr] <= r_s1_data;
        end
        if (s1_adv) begin
            r_pop_data <= r_ring[r_rd_ptr];
        end
    end

    assign o_res_valid  = r_res_vld;
    assign o_status     = r_status;
    assign o_out_valid  = r_popv;
    assign o_out_byte   = r_popv ? r_pop_data : 8'd0;
    assign o_rearm      = r_rearm;
    assign o_stalled    = r_stall_flag;
    assign o_drop_count = r_drop_cnt;
    assign o_fill_level = r_fill[7:0];

    // checks
    `HRDF_ASSERT_NOW(a_ring_reserve, i_clk, i_rst_n, 1'b1, used <= FW'(RING_DEPTH - 1))
    `HRDF_ASSERT_NEXT(a_refuse_counts, i_clk, i_rst_n, s1_adv && s1_cmd == hrdf_pkg::CMD_HEADER && hdr_dec.status == hrdf_pkg::ST_HDR_REF, r_stall_flag && r_drop_cnt == 16'($past(r_drop_cnt) + 16'd1))
    `HRDF_ASSERT_NOW(a_pop_is_idle, i_clk, i_rst_n, r_res_vld && r_popv, r_status == hrdf_pkg::ST_IDLE && !r_rearm)
    `HRDF_ASSERT_NEXT(a_pop_moves_rd, i_clk, i_rst_n, s1_adv && do_read, r_rd_ptr == $past(rd_next) && r_wr_ptr == $past(r_wr_ptr))

endmodule

[rtl/hrdf_hdr_check.sv]
// Header validation and payload length clamping.
`timescale 1ns / 1ps

module hrdf_hdr_check #(
    parameter int PACKET_MAX_BYTES = 64,
    parameter int FREE_W           = 9
) (
    input  logic [6:0]        i_count,
    input  logic [7:0]        i_id,
    input  logic [7:0]        i_len,
    input  logic [FREE_W-1:0] i_free,
    output hrdf_pkg::t_hdr_dec o_dec
);

    logic [6:0] cnt_m2;
    logic [7:0] len_a;
    logic [7:0] len_b;
    logic       bad_count;
    logic       bad_id;

    always_comb begin
        cnt_m2    = i_count - 7'd2;
        bad_count = (i_count < 7'd2) || (i_count > 7'(PACKET_MAX_BYTES));
        bad_id    = (i_id != hrdf_pkg::ID_SMALL) && (i_id != hrdf_pkg::ID_LARGE);

        // clamp to bytes present, then to the per-id cap
        len_a = (i_len > {1'b0, cnt_m2}) ? {1'b0, cnt_m2} : i_len;
        len_b = len_a;
        if (i_id == hrdf_pkg::ID_SMALL && len_a > hrdf_pkg::CAP_SMALL) begin
            len_b = hrdf_pkg::CAP_SMALL;
        end else if (i_id == hrdf_pkg::ID_LARGE && len_a > hrdf_pkg::CAP_LARGE) begin
            len_b = hrdf_pkg::CAP_LARGE;
        end

        o_dec.len = 5'd0;
        if (bad_count || bad_id || len_b == 8'd0) begin
            o_dec.status = hrdf_pkg::ST_HDR_IGN;
        end else if (FREE_W'(len_b[4:0]) > i_free) begin
            o_dec.status = hrdf_pkg::ST_HDR_REF;
        end else begin
            o_dec.status = hrdf_pkg::ST_HDR_OK;
            o_dec.len    = len_b[4:0];
        end
    end

endmodule

[bench/hid_report_rx_deframer_fifo_top_tb.sv]
// Self-checking bench for the HID report deframer and byte ring.
`timescale 1ns / 1ps

module hid_report_rx_deframer_fifo_top_tb;
    import hrdf_pkg::*;

    // Block build under test: default ring and packet sizes.
    localparam int RING_SLOTS   = 256;
    localparam int MAX_PACKET   = 64;
    // Random command words after the directed opening.
    localparam int RANDOM_WORDS = 1350;
    // Long receiver hold-off, in cycles, to back the block up to its input.
    localparam int HOLD_CYCLES  = 250;
    // Idle cycles after the last result, to catch stray result words.
    localparam int DRAIN_CYCLES = 10;
    // Hard stop: far above the slowest legal run (gaps, stalls and holds).
    localparam int CYCLE_LIMIT  = 400000;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_item_valid;
    logic        o_item_stall;
    logic [1:0]  i_cmd;
    logic [6:0]  i_packet_bytes;
    logic [7:0]  i_report_id;
    logic [7:0]  i_length_field;
    logic [7:0]  i_data_byte;
    logic        o_res_valid;
    logic        i_res_stall;
    logic [2:0]  o_status;
    logic [7:0]  o_out_byte;
    logic        o_out_valid;
    logic        o_rearm;
    logic        o_stalled;
    logic [15:0] o_drop_count;
    logic [7:0]  o_fill_level;

    // One result word as the block should report it.
    typedef struct {
        t_status     status;
        logic [7:0]  out_byte;
        logic        out_valid;
        logic        rearm;
        logic        stalled;
        logic [15:0] drop_count;
        logic [7:0]  fill_level;
    } t_ring_result;

    // Mirror of the deframer state plus the queue of result words still owed.
    class deframer_scoreboard;
        logic [7:0]   ring_bytes [RING_SLOTS];
        int           wr_ptr;
        int           rd_ptr;
        bit           stall_set;
        logic [15:0]  drops;
        int           store_left;
        int           packet_left;
        int           mismatches;
        t_ring_result awaited_results [$];

        function new();
            wr_ptr      = 0;
            rd_ptr      = 0;
            stall_set   = 1'b0;
            drops       = 16'd0;
            store_left  = 0;
            packet_left = 0;
            mismatches  = 0;
        endfunction

        function int fill();
            return (wr_ptr - rd_ptr + RING_SLOTS) % RING_SLOTS;
        endfunction

        // Header check and length clamp; a new header drops any unfinished packet.
        function t_status take_header(int n, int id, int len);
            int cap;
            store_left  = 0;
            packet_left = (n >= 2) ? n - 2 : 0;
            if (n < 2 || n > MAX_PACKET)
                return ST_HDR_IGN;
            if (id != ID_SMALL && id != ID_LARGE)
                return ST_HDR_IGN;
            cap = (id == ID_SMALL) ? CAP_SMALL : CAP_LARGE;
            if (len > n - 2)
                len = n - 2;
            if (len > cap)
                len = cap;
            if (len == 0)
                return ST_HDR_IGN;
            if (len > RING_SLOTS - 1 - fill()) begin
                drops++;
                stall_set = 1'b1;
                return ST_HDR_REF;
            end
            store_left = len;
            return ST_HDR_OK;
        endfunction

        function t_status take_byte(logic [7:0] b);
            if (packet_left > 0)
                packet_left--;
            if (store_left > 0) begin
                store_left--;
                if (fill() < RING_SLOTS - 1) begin
                    ring_bytes[wr_ptr] = b;
                    wr_ptr = (wr_ptr + 1) % RING_SLOTS;
                    return ST_STORED;
                end
            end
            return ST_DISCARDED;
        endfunction

        // Accepted command word: advance the mirror and queue the result it owes.
        function void note_word(t_cmd c, logic [6:0] n, logic [7:0] id,
                                logic [7:0] len, logic [7:0] db);
            t_ring_result r;
            r.status    = ST_IDLE;
            r.out_byte  = 8'd0;
            r.out_valid = 1'b0;
            r.rearm     = 1'b0;
            case (c)
                CMD_HEADER: r.status = take_header(n, id, len);
                CMD_BYTE:   r.status = take_byte(db);
                CMD_POP: begin
                    if (wr_ptr != rd_ptr) begin
                        r.out_byte  = ring_bytes[rd_ptr];
                        r.out_valid = 1'b1;
                        rd_ptr      = (rd_ptr + 1) % RING_SLOTS;
                    end
                end
                default: begin
                    if (stall_set) begin
                        stall_set = 1'b0;
                        r.rearm   = 1'b1;
                    end
                end
            endcase
            r.stalled    = stall_set;
            r.drop_count = drops;
            r.fill_level = 8'(fill());
            awaited_results.push_back(r);
        endfunction

        function void compare_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                mismatches++;
                $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
            end
        endfunction

        function void check_word(logic [2:0] status, logic [7:0] out_byte,
                                 logic out_valid, logic rearm, logic stalled,
                                 logic [15:0] drop_count, logic [7:0] fill_level);
            t_ring_result want;
            if (awaited_results.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result word, expected none, actual status %h",
                         $time, status);
                return;
            end
            want = awaited_results.pop_front();
            compare_field("status",     want.status,     status);
            compare_field("out_byte",   want.out_byte,   out_byte);
            compare_field("out_valid",  want.out_valid,  out_valid);
            compare_field("rearm",      want.rearm,      rearm);
            compare_field("stalled",    want.stalled,    stalled);
            compare_field("drop_count", want.drop_count, drop_count);
            compare_field("fill_level", want.fill_level, fill_level);
        endfunction
    endclass

    deframer_scoreboard board;

    int burst_left  = 0;   // words left in the sender's current burst
    int words_sent  = 0;
    int holds_asked = 0;   // bumped by the stimulus, served by the receiver
    int holds_done  = 0;
    int cycles      = 0;

    hid_report_rx_deframer_fifo_top #(
        .RING_DEPTH       (RING_SLOTS),
        .PACKET_MAX_BYTES (MAX_PACKET)
    ) DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_item_valid   (i_item_valid),
        .o_item_stall   (o_item_stall),
        .i_cmd          (i_cmd),
        .i_packet_bytes (i_packet_bytes),
        .i_report_id    (i_report_id),
        .i_length_field (i_length_field),
        .i_data_byte    (i_data_byte),
        .o_res_valid    (o_res_valid),
        .i_res_stall    (i_res_stall),
        .o_status       (o_status),
        .o_out_byte     (o_out_byte),
        .o_out_valid    (o_out_valid),
        .o_rearm        (o_rearm),
        .o_stalled      (o_stalled),
        .o_drop_count   (o_drop_count),
        .o_fill_level   (o_fill_level)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Result side: every word taken off the output is checked against the
    // oldest word still owed. Sampled at the rising edge; stall only moves
    // at the falling edge, so there is no race with the block.
    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid && !i_res_stall)
            board.check_word(o_status, o_out_byte, o_out_valid, o_rearm,
                             o_stalled, o_drop_count, o_fill_level);
    end

    // Receiver stall pattern: segments of random length, each with its own
    // stall density (none, light, half, heavy). A hold request from the
    // stimulus overrides it with a long solid stall, so the input register
    // fills and o_item_stall has to rise while the sender keeps offering.
    initial begin
        int hold_left;
        int seg_left;
        int stall_pct;
        hold_left = 0;
        seg_left  = 0;
        stall_pct = 0;
        i_res_stall <= 1'b0;
        forever begin
            @(negedge i_clk);
            if (holds_done != holds_asked) begin
                holds_done++;
                hold_left = HOLD_CYCLES;
            end
            if (seg_left == 0) begin
                seg_left = $urandom_range(20, 150);
                case ($urandom_range(0, 3))
                    0: stall_pct = 0;
                    1: stall_pct = 25;
                    2: stall_pct = 50;
                    default: stall_pct = 85;
                endcase
            end
            seg_left--;
            if (hold_left > 0) begin
                hold_left--;
                i_res_stall <= 1'b1;
            end else begin
                i_res_stall <= ($urandom_range(0, 99) < stall_pct);
            end
        end
    end

    // Offer one command word and wait for it to be taken. The sender runs in
    // bursts; between bursts valid drops for a random gap. Within a burst
    // valid stays high from word to word, and the payload holds while stalled.
    task automatic send_word(input t_cmd c, input logic [6:0] n, input logic [7:0] id,
                             input logic [7:0] len, input logic [7:0] db);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 32);
            if (gap > 0) begin
                i_item_valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
        end
        i_cmd          <= c;
        i_packet_bytes <= n;
        i_report_id    <= id;
        i_length_field <= len;
        i_data_byte    <= db;
        i_item_valid   <= 1'b1;
        @(posedge i_clk);
        while (o_item_stall)
            @(posedge i_clk);
        board.note_word(c, n, id, len, db);
        burst_left--;
        words_sent++;
        @(negedge i_clk);
    endtask

    // Non-header word; the header fields are don't-care, so they carry noise.
    task automatic send_op(input t_cmd c, input logic [7:0] db);
        send_word(c, 7'($urandom), 8'($urandom), 8'($urandom), db);
    endtask

    // One host packet: header then its body bytes, mostly well formed.
    // Some packets get a stray id or count, some are cut short (the next
    // header then replaces them), some run past their declared length.
    task automatic send_packet(input int pop_pct);
        logic [7:0] id;
        logic [6:0] n;
        logic [7:0] len;
        int         body;
        if ($urandom_range(0, 9) == 0)
            id = 8'($urandom);
        else
            id = $urandom_range(0, 1) ? ID_SMALL : ID_LARGE;
        if ($urandom_range(0, 9) == 0)
            n = 7'($urandom);
        else
            n = 7'($urandom_range(3, MAX_PACKET));
        if (n >= 3 && $urandom_range(0, 3) != 0)
            len = 8'($urandom_range(1, int'(n) - 2));
        else
            len = 8'($urandom);
        body = (n >= 2) ? int'(n) - 2 : 0;
        case ($urandom_range(0, 9))
            0:       body = $urandom_range(0, body);
            1:       body = body + $urandom_range(1, 4);
            default: ;
        endcase
        send_word(CMD_HEADER, n, id, len, 8'($urandom));
        repeat (body) begin
            if ($urandom_range(0, 99) < pop_pct)
                send_op(CMD_POP, 8'($urandom));
            send_op(CMD_BYTE, 8'($urandom));
        end
    endtask

    initial begin
        int rand_start;
        int episode;
        int pop_pct;
        int pick;
        board = new();
        i_rst_n        <= 1'b0;
        i_item_valid   <= 1'b0;
        i_cmd          <= CMD_POP;
        i_packet_bytes <= 7'd0;
        i_report_id    <= 8'd0;
        i_length_field <= 8'd0;
        i_data_byte    <= 8'd0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed opening: empty ring and idle stall flag first.
        send_op(CMD_POP, 8'h00);                               // pop, ring empty
        send_op(CMD_REARM, 8'h00);                             // rearm, no stall
        send_op(CMD_BYTE, 8'hff);                              // byte with no header
        // Headers that must be ignored.
        send_word(CMD_HEADER, 7'd0, ID_SMALL, 8'd5, 8'h00);    // empty packet
        send_word(CMD_HEADER, 7'd1, ID_SMALL, 8'd5, 8'h00);    // count below two
        send_word(CMD_HEADER, 7'(MAX_PACKET + 1), ID_SMALL, 8'd5, 8'h00);  // oversized
        send_word(CMD_HEADER, 7'd127, ID_LARGE, 8'd255, 8'h00);
        send_word(CMD_HEADER, 7'd10, 8'd0, 8'd5, 8'h00);       // unknown id
        send_word(CMD_HEADER, 7'd10, 8'd255, 8'd5, 8'h00);
        send_word(CMD_HEADER, 7'd2, ID_SMALL, 8'd5, 8'h00);    // clamps to zero
        send_word(CMD_HEADER, 7'd10, ID_LARGE, 8'd0, 8'h00);   // length zero
        // Largest packet, id 1 cap; cut short by a new header mid-packet.
        send_word(CMD_HEADER, 7'(MAX_PACKET), ID_SMALL, 8'd255, 8'h00);
        send_op(CMD_BYTE, 8'h00);
        send_op(CMD_BYTE, 8'hff);
        // Length clamped to the bytes present, then one byte past the payload.
        send_word(CMD_HEADER, 7'd5, ID_LARGE, 8'd255, 8'h00);
        send_op(CMD_BYTE, 8'haa);
        send_op(CMD_BYTE, 8'h55);
        send_op(CMD_BYTE, 8'h01);
        send_op(CMD_BYTE, 8'h7f);
        send_op(CMD_POP, 8'h00);
        send_op(CMD_POP, 8'h00);
        send_word(CMD_HEADER, 7'(MAX_PACKET), ID_LARGE, 8'd29, 8'h00);  // id 2 cap
        send_op(CMD_BYTE, 8'h80);
        send_op(CMD_REARM, 8'h00);
        send_op(CMD_POP, 8'h00);

        // Random part in episodes. The first one sends no pop bursts, so the ring
        // fills up and headers get refused (stall set, drop count moves),
        // and later headers arrive while stalled. Others drain or mix.
        // The first episode always asks for a long hold.
        rand_start = words_sent;
        episode    = 0;
        while (words_sent - rand_start < RANDOM_WORDS) begin
            case ((episode == 0) ? 0 : $urandom_range(0, 2))
                0:       pop_pct = 0;
                1:       pop_pct = 60;
                default: pop_pct = 25;
            endcase
            if (episode % 4 == 0)
                holds_asked++;
            repeat ((episode == 0) ? 40 : $urandom_range(8, 30)) begin
                if (words_sent - rand_start >= RANDOM_WORDS)
                    break;
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    send_word(t_cmd'($urandom_range(0, 3)), 7'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom));
                else if (pick < 10 + pop_pct / 2)
                    repeat ($urandom_range(1, 6)) send_op(CMD_POP, 8'($urandom));
                else if (pick < 16 + pop_pct / 2 || (board.stall_set && pick < 40))
                    send_op(CMD_REARM, 8'($urandom));
                else
                    send_packet(pop_pct);
            end
            episode++;
        end
        i_item_valid <= 1'b0;

        // Wait for every owed word, then a few quiet cycles for strays.
        while (board.awaited_results.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (board.mismatches == 0 && board.awaited_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/hrdf_pkg.sv
rtl/hrdf_hdr_check.sv
rtl/hid_report_rx_deframer_fifo_top.sv
bench/hid_report_rx_deframer_fifo_top_tb.sv
